/* rtl/stwa_pkg.sv */
package stwa_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 64;

    typedef enum logic [2:0] {
        ACT_CLEAR    = 3'd0,
        ACT_SWAP     = 3'd1,
        ACT_INSERT   = 3'd2,
        ACT_DELETE   = 3'd3,
        ACT_READ     = 3'd4,
        ACT_ALLOCATE = 3'd5,
        ACT_RELEASE  = 3'd6,
        ACT_FIND     = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_RESERVED = 2'd1,
        ST_OCCUPIED = 2'd2
    } t_status;

    typedef struct packed {
        t_action     action;
        logic [7:0]  slot_a;
        logic [7:0]  slot_b;
        logic [63:0] item_in;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [7:0]  slot_out;
        logic [63:0] item_out;
        logic [7:0]  used_count;
    } t_rsp;

    // Token that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        t_action     act;
        logic [7:0]  slot_a;     // for swap: the lower index
        logic [7:0]  slot_b;     // for swap: the higher index
        logic [63:0] item;
        logic        live;
        logic        pass;
        logic        ok;
        logic        hit;
        logic [7:0]  idx;
        logic [63:0] item_out;
        t_status     carry_st;
        logic [63:0] carry_item;
    } t_tok;

endpackage

/* rtl/stwa_cell.sv */
module stwa_cell import stwa_pkg::*; #(
    parameter int unsigned IDX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_tok i_tok,
    output logic o_vld,
    output t_tok o_tok
);

    localparam logic [7:0] MyIdx = 8'(IDX);

    t_status     r_status, n_status;
    logic [63:0] r_item, n_item;
    logic        r_vld;
    t_tok        r_tok, n_tok;
    logic        at_a, at_b;

    assign at_a = (i_tok.slot_a == MyIdx);
    assign at_b = (i_tok.slot_b == MyIdx);

    always_comb begin
        n_tok    = i_tok;
        n_status = r_status;
        n_item   = r_item;
        if (i_vld && i_tok.live) begin
            case (i_tok.act)
                ACT_CLEAR: begin
                    n_status = ST_FREE;
                end
                ACT_SWAP: begin
                    // The first pass picks up the higher slot; the second pass
                    // exchanges it with the lower slot and drops that one at the higher.
                    if (!i_tok.pass) begin
                        if (at_b) begin
                            n_tok.carry_st   = r_status;
                            n_tok.carry_item = r_item;
                        end
                    end else if (at_a) begin
                        n_status         = i_tok.carry_st;
                        n_item           = i_tok.carry_item;
                        n_tok.carry_st   = r_status;
                        n_tok.carry_item = r_item;
                    end else if (at_b) begin
                        n_status = i_tok.carry_st;
                        n_item   = i_tok.carry_item;
                    end
                end
                ACT_INSERT: begin
                    if (at_a && r_status == ST_RESERVED) begin
                        n_status = ST_OCCUPIED;
                        n_item   = i_tok.item;
                        n_tok.ok = 1'b1;
                    end
                end
                ACT_DELETE: begin
                    if (at_a && r_status == ST_OCCUPIED) begin
                        n_status       = ST_FREE;
                        n_item         = '0;
                        n_tok.item_out = r_item;
                        n_tok.ok       = 1'b1;
                    end
                end
                ACT_READ: begin
                    if (at_a && r_status == ST_OCCUPIED) begin
                        n_tok.item_out = r_item;
                        n_tok.ok       = 1'b1;
                    end
                end
                ACT_ALLOCATE: begin
                    if (!i_tok.hit && r_status == ST_FREE) begin
                        n_status  = ST_RESERVED;
                        n_tok.hit = 1'b1;
                        n_tok.idx = MyIdx;
                        n_tok.ok  = 1'b1;
                    end
                end
                ACT_RELEASE: begin
                    if (at_a && r_status == ST_RESERVED) begin
                        n_status = ST_FREE;
                        n_tok.ok = 1'b1;
                    end
                end
                ACT_FIND: begin
                    if (!i_tok.hit && r_status == ST_OCCUPIED && r_item == i_tok.item) begin
                        n_tok.hit = 1'b1;
                        n_tok.idx = MyIdx;
                        n_tok.ok  = 1'b1;
                    end
                end
                default: begin
                    n_tok = i_tok;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_status <= ST_FREE;
        end else begin
            r_vld    <= i_vld;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok  <= n_tok;
        r_item <= n_item;
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

endmodule

/* rtl/slot_table_with_allocator.sv */
// Slot table with allocator.
// A request beat (action, slot_a, slot_b, item_in) is taken at a rising edge where
// start is high and busy is low. The request travels as a token down a row of
// SLOT_COUNT cells, one cell per cycle; each cell holds one slot's state and
// identifier and applies the action as the token passes. Allocate and find take
// the first matching cell, so the lowest slot wins.
// The result beat appears on o_rsp with o_done high for one cycle; a swap makes
// two passes down the row. busy stays high until the result beat, so one
// request is in flight at a time. The next request can be taken at the edge that
// ends the result beat.
// The receiver cannot stall: a result beat is presented once and must be taken.
// Reset (synchronous, active low) marks every slot free, zeroes the occupied
// count and drops any request in flight. Identifiers are not cleared; they are
// only ever read from occupied slots.
module slot_table_with_allocator import stwa_pkg::*; #(
    parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam logic [7:0] SlotLim = 8'(SLOT_COUNT);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state      r_state, n_state;
    logic        r_head_vld, n_head_vld;
    t_tok        r_head, n_head;
    logic        r_done;
    t_rsp        r_rsp, n_rsp;
    logic [7:0]  r_used, n_used;

    logic        vld_c [0:SLOT_COUNT];
    t_tok        tok_c [0:SLOT_COUNT];

    logic        accept;
    logic        loop_back;
    logic        emit;
    logic        a_in, b_in, swap_ok;
    t_tok        new_tok;
    t_tok        tail;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    assign a_in    = (i_req.slot_a < SlotLim);
    assign b_in    = (i_req.slot_b < SlotLim);
    assign swap_ok = a_in && b_in;

    always_comb begin
        new_tok            = '0;
        new_tok.act        = i_req.action;
        new_tok.slot_a     = i_req.slot_a;
        new_tok.slot_b     = i_req.slot_b;
        new_tok.item       = i_req.item_in;
        new_tok.live       = 1'b1;
        new_tok.carry_st   = ST_FREE;
        case (i_req.action)
            ACT_CLEAR: begin
                new_tok.ok = 1'b1;
            end
            ACT_SWAP: begin
                new_tok.ok   = swap_ok;
                // Swapping a slot with itself changes nothing.
                new_tok.live = swap_ok && (i_req.slot_a != i_req.slot_b);
                if (i_req.slot_b < i_req.slot_a) begin
                    new_tok.slot_a = i_req.slot_b;
                    new_tok.slot_b = i_req.slot_a;
                end
            end
            default: begin
                new_tok.ok = 1'b0;
            end
        endcase
    end

    assign vld_c[0] = r_head_vld;
    assign tok_c[0] = r_head;

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        stwa_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (vld_c[g]),
            .i_tok   (tok_c[g]),
            .o_vld   (vld_c[g+1]),
            .o_tok   (tok_c[g+1])
        );
    end

    assign tail      = tok_c[SLOT_COUNT];
    assign loop_back = vld_c[SLOT_COUNT] && tail.act == ACT_SWAP && tail.live && !tail.pass;
    assign emit      = vld_c[SLOT_COUNT] && !loop_back;

    always_comb begin
        n_head_vld = accept || loop_back;
        n_head     = new_tok;
        if (loop_back) begin
            n_head      = tail;
            n_head.pass = 1'b1;
        end
    end

    always_comb begin
        n_used = r_used;
        if (emit) begin
            case (tail.act)
                ACT_CLEAR: begin
                    n_used = '0;
                end
                ACT_INSERT: begin
                    if (tail.ok) begin
                        n_used = r_used + 8'd1;
                    end
                end
                ACT_DELETE: begin
                    if (tail.ok && r_used != 8'd0) begin
                        n_used = r_used - 8'd1;
                    end
                end
                default: begin
                    n_used = r_used;
                end
            endcase
        end
    end

    always_comb begin
        n_rsp.ok         = tail.ok;
        n_rsp.slot_out   = tail.hit ? tail.idx : 8'd0;
        n_rsp.item_out   = tail.item_out;
        n_rsp.used_count = n_used;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head_vld <= 1'b0;
            r_done     <= 1'b0;
            r_used     <= '0;
        end else begin
            r_state    <= n_state;
            r_head_vld <= n_head_vld;
            r_done     <= emit;
            r_used     <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        if (emit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

/* tb/tb.sv */
module tb;
    import stwa_pkg::*;

    localparam int SLOT_N   = SLOT_COUNT_DEF;
    localparam int N_ITEMS  = 1800;
    // The longest quiet stretch is a swap pass plus the longest sender gap.
    localparam int WATCHDOG = 8 * (2 * SLOT_N + 3) + 200;

    // Shadow of the slot table: predicts each result beat and checks it.
    class slot_shadow;
        t_status     st[SLOT_N];
        logic [63:0] id[SLOT_N];
        int          used;
        t_rsp        pending_rsp[$];
        int          errors;
        int          n_req;
        int          n_rsp;
        int          n_reject;
        int          n_full;
        int          n_find_hit;
        int          peak_used;

        function new();
            foreach (st[i]) begin
                st[i] = ST_FREE;
                id[i] = '0;
            end
            used = 0;
            errors = 0;
            n_req = 0;
            n_rsp = 0;
            n_reject = 0;
            n_full = 0;
            n_find_hit = 0;
            peak_used = 0;
        endfunction

        // Applies one request to the shadow and returns the beat it should produce.
        function t_rsp apply_action(t_req r);
            t_rsp        o;
            t_status     ts;
            logic [63:0] ti;
            bit          a_in;
            bit          b_in;
            o = '0;
            a_in = r.slot_a < SLOT_N;
            b_in = r.slot_b < SLOT_N;
            case (r.action)
                ACT_CLEAR: begin
                    foreach (st[i]) st[i] = ST_FREE;
                    used = 0;
                    o.ok = 1'b1;
                end
                ACT_SWAP: begin
                    if (a_in && b_in) begin
                        ts = st[r.slot_a];
                        ti = id[r.slot_a];
                        st[r.slot_a] = st[r.slot_b];
                        id[r.slot_a] = id[r.slot_b];
                        st[r.slot_b] = ts;
                        id[r.slot_b] = ti;
                        o.ok = 1'b1;
                    end
                end
                ACT_INSERT: begin
                    if (a_in && st[r.slot_a] == ST_RESERVED) begin
                        id[r.slot_a] = r.item_in;
                        st[r.slot_a] = ST_OCCUPIED;
                        used++;
                        o.ok = 1'b1;
                    end
                end
                ACT_DELETE: begin
                    if (a_in && st[r.slot_a] == ST_OCCUPIED) begin
                        o.item_out = id[r.slot_a];
                        id[r.slot_a] = '0;
                        st[r.slot_a] = ST_FREE;
                        if (used > 0) used--;
                        o.ok = 1'b1;
                    end
                end
                ACT_READ: begin
                    if (a_in && st[r.slot_a] == ST_OCCUPIED) begin
                        o.item_out = id[r.slot_a];
                        o.ok = 1'b1;
                    end
                end
                ACT_ALLOCATE: begin
                    for (int i = 0; i < SLOT_N; i++) begin
                        if (st[i] == ST_FREE) begin
                            st[i] = ST_RESERVED;
                            o.slot_out = 8'(i);
                            o.ok = 1'b1;
                            break;
                        end
                    end
                    if (!o.ok) n_full++;
                end
                ACT_RELEASE: begin
                    if (a_in && st[r.slot_a] == ST_RESERVED) begin
                        st[r.slot_a] = ST_FREE;
                        o.ok = 1'b1;
                    end
                end
                default: begin
                    for (int i = 0; i < SLOT_N; i++) begin
                        if (st[i] == ST_OCCUPIED && id[i] == r.item_in) begin
                            o.slot_out = 8'(i);
                            o.ok = 1'b1;
                            break;
                        end
                    end
                    if (o.ok) n_find_hit++;
                end
            endcase
            if (!o.ok) n_reject++;
            if (used > peak_used) peak_used = used;
            o.used_count = 8'(used);
            return o;
        endfunction

        function void note_request(t_req r);
            pending_rsp.push_back(apply_action(r));
            n_req++;
        endfunction

        function void check_result(t_rsp got);
            t_rsp exp;
            n_rsp++;
            if (pending_rsp.size() == 0) begin
                $error("result beat with no request waiting: %0h", got);
                errors++;
                return;
            end
            exp = pending_rsp.pop_front();
            if (got.ok !== exp.ok) begin
                $error("ok: expected %0h, got %0h", exp.ok, got.ok);
                errors++;
            end
            if (got.slot_out !== exp.slot_out) begin
                $error("slot_out: expected %0h, got %0h", exp.slot_out, got.slot_out);
                errors++;
            end
            if (got.item_out !== exp.item_out) begin
                $error("item_out: expected %0h, got %0h", exp.item_out, got.item_out);
                errors++;
            end
            if (got.used_count !== exp.used_count) begin
                $error("used_count: expected %0h, got %0h", exp.used_count, got.used_count);
                errors++;
            end
        endfunction

        // Random slot in the given state, or -1 when there is none.
        function int pick(t_status want);
            int hits[$];
            for (int i = 0; i < SLOT_N; i++) begin
                if (st[i] == want) hits.push_back(i);
            end
            if (hits.size() == 0) return -1;
            return hits[$urandom_range(0, hits.size() - 1)];
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    t_req        i_req = '0;
    logic        busy;
    logic        o_done;
    t_rsp        o_rsp;

    slot_shadow  sb;
    logic [63:0] id_pool[6];
    bit          no_idle = 1'b0;
    int          sent = 0;
    int          idle_cycles = 0;

    slot_table_with_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_rsp);
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_req mk(t_action act, int sa, int sb_idx, logic [63:0] it);
        t_req r;
        r.action = act;
        r.slot_a = 8'(sa);
        r.slot_b = 8'(sb_idx);
        r.item_in = it;
        return r;
    endfunction

    // Start stays high across back-to-back beats; it only drops when a gap is drawn.
    task automatic send(t_req r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(r);
        sent++;
    endtask

    // Start must drop here, or the last beat would be taken again once busy clears.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_id();
        if ($urandom_range(0, 1)) return id_pool[$urandom_range(0, 5)];
        return {$urandom, $urandom};
    endfunction

    function automatic int slot_or_any(t_status want);
        int s;
        s = sb.pick(want);
        if (s < 0 || $urandom_range(0, 9) == 0) s = $urandom_range(0, SLOT_N - 1);
        return s;
    endfunction

    // Mostly well-formed requests aimed at slots in the right state, with some noise.
    function automatic t_req make_item();
        t_req r;
        int   p;
        int   s;
        r.action = t_action'($urandom_range(0, 7));
        r.slot_a = 8'($urandom);
        r.slot_b = 8'($urandom);
        r.item_in = {$urandom, $urandom};
        p = $urandom_range(0, 99);
        if (p < 18) begin
            r.action = ACT_ALLOCATE;
        end else if (p < 38) begin
            r.action = ACT_INSERT;
            r.slot_a = 8'(slot_or_any(ST_RESERVED));
            r.item_in = pick_id();
        end else if (p < 48) begin
            r.action = ACT_READ;
            r.slot_a = 8'(slot_or_any(ST_OCCUPIED));
        end else if (p < 60) begin
            r.action = ACT_FIND;
            s = sb.pick(ST_OCCUPIED);
            r.item_in = (s >= 0 && $urandom_range(0, 1)) ? sb.id[s] : pick_id();
        end else if (p < 67) begin
            r.action = ACT_DELETE;
            r.slot_a = 8'(slot_or_any(ST_OCCUPIED));
        end else if (p < 73) begin
            r.action = ACT_RELEASE;
            r.slot_a = 8'(slot_or_any(ST_RESERVED));
        end else if (p < 79) begin
            r.action = ACT_SWAP;
            r.slot_a = 8'($urandom_range(0, SLOT_N - 1));
            r.slot_b = $urandom_range(0, 3) == 0 ? r.slot_a : 8'($urandom_range(0, SLOT_N - 1));
        end else if (p < 80) begin
            r.action = ACT_CLEAR;
        end
        return r;
    endfunction

    initial begin
        sb = new();
        id_pool[0] = '0;
        id_pool[1] = '1;
        id_pool[2] = 64'h8000_0000_0000_0001;
        id_pool[3] = {$urandom, $urandom};
        id_pool[4] = {$urandom, $urandom};
        id_pool[5] = {$urandom, $urandom};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(mk(ACT_READ, 0, 0, '0));
        send(mk(ACT_ALLOCATE, 0, 0, '0));
        send(mk(ACT_ALLOCATE, 0, 0, '0));
        send(mk(ACT_INSERT, 0, 0, '0));
        send(mk(ACT_INSERT, 1, 0, '1));
        send(mk(ACT_INSERT, 0, 0, 64'h1234));
        send(mk(ACT_INSERT, 2, 0, 64'h1234));
        send(mk(ACT_READ, 1, 0, '0));
        send(mk(ACT_FIND, 0, 0, '0));
        send(mk(ACT_FIND, 0, 0, 64'h1234));
        send(mk(ACT_SWAP, 0, 1, '0));
        send(mk(ACT_READ, 0, 0, '0));
        send(mk(ACT_SWAP, 3, 3, '0));
        send(mk(ACT_SWAP, 0, SLOT_N, '0));
        send(mk(ACT_SWAP, 255, 0, '1));
        send(mk(ACT_READ, SLOT_N, 0, '0));
        send(mk(ACT_INSERT, 255, 255, '1));
        send(mk(ACT_ALLOCATE, 255, 255, '1));
        send(mk(ACT_RELEASE, 2, 0, '0));
        send(mk(ACT_RELEASE, 2, 0, '0));
        send(mk(ACT_DELETE, 1, 0, '0));
        send(mk(ACT_DELETE, 1, 0, '0));
        send(mk(ACT_FIND, 0, 0, '1));
        send(mk(ACT_CLEAR, 0, 0, '0));
        send(mk(ACT_READ, 0, 0, '0));

        // Let the table settle with nothing in flight before the random part.
        drain();

        while (sent < N_ITEMS) begin
            if ($urandom_range(0, 149) == 0) no_idle = ~no_idle;
            if ($urandom_range(0, 499) == 0) drain();
            // Occasionally fill the whole table so a full-table allocate is refused.
            if ($urandom_range(0, 149) == 0) begin
                repeat (SLOT_N + 2) send(mk(ACT_ALLOCATE, $urandom, $urandom,
                                            {$urandom, $urandom}));
            end
            send(make_item());
        end
        start <= 1'b0;

        drain();
        repeat (2 * SLOT_N + 8) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d result beats; %0d were refused.",
                 sb.n_req, sb.n_rsp, sb.n_reject);
        $display("Full-table allocates: %0d, find hits: %0d, peak occupancy: %0d.",
                 sb.n_full, sb.n_find_hit, sb.peak_used);
        if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
